### hdl/code_lock_tamper_alarm_macros.svh
// Assertion helpers for the lock and alarm logic.
`ifndef CODE_LOCK_TAMPER_ALARM_MACROS_SVH
`define CODE_LOCK_TAMPER_ALARM_MACROS_SVH

`ifndef SYNTHESIS
// Check a property on every clock edge outside reset.
`define CLTA_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Check that a condition implies a property in the cycle after it.
`define CLTA_ASSERT_NEXT(lbl, clk, rst_n, cond, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
    else $error(msg);
`else
`define CLTA_ASSERT(lbl, clk, rst_n, prop, msg)
`define CLTA_ASSERT_NEXT(lbl, clk, rst_n, cond, prop, msg)
`endif

`endif

### hdl/clta_pkg.sv
package clta_pkg;

  typedef enum logic [2:0] {
    CMD_POLL  = 3'd0,
    CMD_ACCEL = 3'd1,
    CMD_POT   = 3'd2,
    CMD_TICK  = 3'd3,
    CMD_FLASH = 3'd4
  } cmd_e;

  typedef enum logic [1:0] {
    MODE_UNARMED = 2'd0,
    MODE_ARMED   = 2'd1,
    MODE_PENDING = 2'd2,
    MODE_ALARMED = 2'd3
  } mode_e;

  // Button bit positions; a level of 0 means pressed.
  localparam int unsigned BTN_LEFT   = 0;
  localparam int unsigned BTN_RIGHT  = 1;
  localparam int unsigned BTN_UP     = 2;
  localparam int unsigned BTN_DOWN   = 3;
  localparam int unsigned BTN_CENTRE = 4;

  // Register indexes.
  localparam logic [2:0] REG_SECRET_0  = 3'd0;
  localparam logic [2:0] REG_THRESHOLD = 3'd4;
  localparam int unsigned NUM_SECRET_REGS = 4;

  localparam logic [3:0] DIGIT_MAX = 4'd9;
  localparam logic [3:0] SECRET_RESET [NUM_SECRET_REGS] = '{4'd1, 4'd2, 4'd3, 4'd4};
  localparam logic signed [9:0] THRESHOLD_RESET = 10'sd50;

  localparam logic [6:0]  SECS_MAX  = 7'd120;
  localparam logic [18:0] SECS_SPAN = 19'd110;
  localparam logic [18:0] POT_ROUND = 19'd4094;

  typedef struct packed {
    logic [2:0]        command;
    logic [4:0]        button_levels;
    logic signed [9:0] accel_x;
    logic signed [9:0] accel_y;
    logic signed [9:0] accel_z;
    logic [11:0]       pot_sample;
  } item_t;

  typedef struct packed {
    mode_e mode;
    logic  lock;
    logic  armed;
    logic  tamper;
    logic  led;
  } status_t;

  // 120 - ceil(110 * pot / 4095); division by 2^12-1 done as
  // floor(m / 4095) = (m + (m >> 12) + 1) >> 12 for m below 2^24 - 1.
  function automatic logic [6:0] pot_to_seconds(input logic [11:0] pot);
    logic [18:0] num;
    logic [19:0] sum;
    logic [6:0]  drop;
    num  = {7'd0, pot} * SECS_SPAN + POT_ROUND;
    sum  = {1'b0, num} + {13'd0, num[18:12]} + 20'd1;
    drop = sum[18:12];
    return SECS_MAX - drop;
  endfunction

endpackage

### hdl/code_lock_tamper_alarm.sv
// Datapath: a transfer loads the input register, and the state/result register
// loads from it when the held event advances.
// Throughput: one event per cycle unless stalled; state update is the only loop.
// Reset (rst_ni low, asynchronous): unarmed, flags clear, entries and countdown
// zero, buttons taken as released, code digits 1,2,3,4 and threshold 50.
module code_lock_tamper_alarm #(
  parameter int unsigned CODE_LEN = 4
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  // configuration writes
  input  logic              cfg_we_i,
  input  logic [2:0]        cfg_index_i,
  input  logic [9:0]        cfg_data_i,
  // event channel
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [2:0]        command_i,
  input  logic [4:0]        button_levels_i,
  input  logic signed [9:0] accel_x_i,
  input  logic signed [9:0] accel_y_i,
  input  logic signed [9:0] accel_z_i,
  input  logic [11:0]       pot_sample_i,
  // result channel
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [1:0]        alarm_status_o,
  output logic              lock_on_o,
  output logic              armed_on_o,
  output logic              tamper_seen_o,
  output logic [1:0]        cursor_o,
  output logic [3:0]        entry_0_o,
  output logic [3:0]        entry_1_o,
  output logic [3:0]        entry_2_o,
  output logic [3:0]        entry_3_o,
  output logic [6:0]        countdown_o,
  output logic              led_lit_o
);

  localparam int unsigned CUR_W = (CODE_LEN > 1) ? $clog2(CODE_LEN) : 1;
  localparam int unsigned NUM_VIEW = 4;

  clta_pkg::item_t   in_item;
  clta_pkg::item_t   held_item;
  clta_pkg::status_t status;
  logic              held_valid;
  logic              adv;
  logic [3:0]        secret [CODE_LEN];
  logic signed [9:0] threshold;
  logic [CUR_W-1:0]  cursor;
  logic [3:0]        entries [CODE_LEN];
  logic [6:0]        seconds;
  logic [3:0]        entry_view [NUM_VIEW];

  // Pack the event fields for the input register.
  assign in_item.command       = command_i;
  assign in_item.button_levels = button_levels_i;
  assign in_item.accel_x       = accel_x_i;
  assign in_item.accel_y       = accel_y_i;
  assign in_item.accel_z       = accel_z_i;
  assign in_item.pot_sample    = pot_sample_i;

  // Code digits and shake threshold; digits past the fourth stay zero.
  clta_cfg_regs #(
    .CODE_LEN (CODE_LEN)
  ) u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .secret_o    (secret),
    .threshold_o (threshold)
  );

  // Input register: takes a transfer when empty or when the held event moves on.
  clta_in_stage u_in (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .item_i     (in_item),
    .adv_i      (adv),
    .valid_o    (held_valid),
    .item_o     (held_item)
  );

  // State update: the state registers double as the result register, so they
  // advance only when the previous result is gone or leaving this cycle.
  clta_core #(
    .CODE_LEN (CODE_LEN)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (held_valid),
    .item_i      (held_item),
    .adv_o       (adv),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .secret_i    (secret),
    .threshold_i (threshold),
    .status_o    (status),
    .cursor_o    (cursor),
    .entries_o   (entries),
    .seconds_o   (seconds)
  );

  // Entry fields past the code length read zero.
  for (genvar i = 0; i < NUM_VIEW; i++) begin : g_view
    if (i < CODE_LEN) begin : g_used
      assign entry_view[i] = entries[i];
    end else begin : g_unused
      assign entry_view[i] = 4'd0;
    end
  end

  // Report the low two bits of the cursor.
  if (CUR_W >= 2) begin : g_cur_wide
    assign cursor_o = cursor[1:0];
  end else begin : g_cur_narrow
    assign cursor_o = {1'b0, cursor};
  end

  assign alarm_status_o = status.mode;
  assign lock_on_o      = status.lock;
  assign armed_on_o     = status.armed;
  assign tamper_seen_o  = status.tamper;
  assign entry_0_o      = entry_view[0];
  assign entry_1_o      = entry_view[1];
  assign entry_2_o      = entry_view[2];
  assign entry_3_o      = entry_view[3];
  assign countdown_o    = seconds;
  assign led_lit_o      = status.led;

endmodule

### hdl/clta_cfg_regs.sv
module clta_cfg_regs #(
  parameter int unsigned CODE_LEN = 4
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [2:0]        cfg_index_i,
  input  logic [9:0]        cfg_data_i,
  output logic [3:0]        secret_o [CODE_LEN],
  output logic signed [9:0] threshold_o
);

  logic signed [9:0] threshold_q;

  for (genvar i = 0; i < CODE_LEN; i++) begin : g_secret
    if (i < clta_pkg::NUM_SECRET_REGS) begin : g_reg
      logic [3:0] digit_q;
      always_ff @(posedge clk_i or negedge rst_ni) begin
        if (!rst_ni) begin
          digit_q <= clta_pkg::SECRET_RESET[i];
        end else if (cfg_we_i && (cfg_index_i == clta_pkg::REG_SECRET_0 + 3'(i))) begin
          digit_q <= cfg_data_i[3:0];
        end
      end
      assign secret_o[i] = digit_q;
    end else begin : g_const
      // no register: digit fixed at zero
      assign secret_o[i] = 4'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      threshold_q <= clta_pkg::THRESHOLD_RESET;
    end else if (cfg_we_i && (cfg_index_i == clta_pkg::REG_THRESHOLD)) begin
      threshold_q <= cfg_data_i;
    end
  end

  assign threshold_o = threshold_q;

endmodule

### hdl/clta_in_stage.sv
module clta_in_stage (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  clta_pkg::item_t     item_i,
  input  logic                adv_i,
  output logic                valid_o,
  output clta_pkg::item_t     item_o
);

  logic            valid_q;
  clta_pkg::item_t item_q;

  // hold while the held item cannot move on
  assign in_stall_o = valid_q && !adv_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      item_q <= item_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

### hdl/clta_core.sv
`include "code_lock_tamper_alarm_macros.svh"

module clta_core #(
  parameter int unsigned CODE_LEN = 4,
  localparam int unsigned CUR_W = (CODE_LEN > 1) ? $clog2(CODE_LEN) : 1
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  valid_i,
  input  clta_pkg::item_t       item_i,
  output logic                  adv_o,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  input  logic [3:0]            secret_i [CODE_LEN],
  input  logic signed [9:0]     threshold_i,
  output clta_pkg::status_t     status_o,
  output logic [CUR_W-1:0]      cursor_o,
  output logic [3:0]            entries_o [CODE_LEN],
  output logic [6:0]            seconds_o
);

  logic               out_valid_q;
  clta_pkg::mode_e    mode_q, mode_d;
  logic               lock_q, lock_d;
  logic               armed_q, armed_d;
  logic               tamper_q, tamper_d;
  logic               led_q, led_d;
  logic [CUR_W-1:0]   cursor_q, cursor_d;
  logic [3:0]         entries_q [CODE_LEN];
  logic [3:0]         entries_d [CODE_LEN];
  logic [6:0]         seconds_q, seconds_d;
  logic [4:0]         last_q, last_d;
  logic               arm_go, disarm_go, shake_go, alarm_go;

  assign adv_o = valid_i && (!out_valid_q || !out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv_o) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // flag, cursor, entry, countdown, led and button history update
  always_comb begin
    logic [4:0] edges;
    logic [3:0] digit;
    logic       match;
    lock_d    = lock_q;
    armed_d   = armed_q;
    tamper_d  = tamper_q;
    led_d     = led_q;
    cursor_d  = cursor_q;
    entries_d = entries_q;
    seconds_d = seconds_q;
    last_d    = last_q;
    arm_go    = 1'b0;
    disarm_go = 1'b0;
    shake_go  = 1'b0;
    alarm_go  = 1'b0;
    edges     = ~last_q & item_i.button_levels;
    digit     = entries_q[cursor_q];
    match     = 1'b1;
    for (int i = 0; i < CODE_LEN; i++) begin
      if (entries_q[i] != secret_i[i]) begin
        match = 1'b0;
      end
    end
    case (clta_pkg::cmd_e'(item_i.command))
      clta_pkg::CMD_POLL: begin
        last_d = item_i.button_levels;
        if (!armed_q) begin
          if (edges[clta_pkg::BTN_UP]) begin
            lock_d = 1'b1;
          end else if (edges[clta_pkg::BTN_DOWN]) begin
            lock_d = 1'b0;
          end else if (edges[clta_pkg::BTN_LEFT] && lock_q) begin
            arm_go  = 1'b1;
            armed_d = 1'b1;
            edges[clta_pkg::BTN_LEFT] = 1'b0;
            edges[clta_pkg::BTN_UP]   = 1'b0;
            edges[clta_pkg::BTN_DOWN] = 1'b0;
          end
        end
        if (armed_d) begin
          if (edges[clta_pkg::BTN_RIGHT]) begin
            if (int'(cursor_q) + 1 < CODE_LEN) begin
              cursor_d = cursor_q + CUR_W'(1);
            end
          end else if (edges[clta_pkg::BTN_LEFT]) begin
            if (cursor_q != '0) begin
              cursor_d = cursor_q - CUR_W'(1);
            end
          end else if (edges[clta_pkg::BTN_UP]) begin
            if (digit < clta_pkg::DIGIT_MAX) begin
              entries_d[cursor_q] = digit + 4'd1;
            end
          end else if (edges[clta_pkg::BTN_DOWN]) begin
            if (digit != 4'd0) begin
              entries_d[cursor_q] = digit - 4'd1;
            end
          end else if (edges[clta_pkg::BTN_CENTRE] && match) begin
            disarm_go = 1'b1;
            armed_d   = 1'b0;
            tamper_d  = 1'b0;
            lock_d    = 1'b0;
          end
        end
      end
      clta_pkg::CMD_ACCEL: begin
        if (armed_q && ((item_i.accel_x > threshold_i) || (item_i.accel_y > threshold_i) ||
                        (item_i.accel_z > threshold_i))) begin
          shake_go = 1'b1;
          tamper_d = 1'b1;
        end
      end
      clta_pkg::CMD_POT: begin
        if (!armed_q) begin
          seconds_d = clta_pkg::pot_to_seconds(item_i.pot_sample);
        end
      end
      clta_pkg::CMD_TICK: begin
        if (mode_q == clta_pkg::MODE_PENDING) begin
          if (seconds_q != 7'd0) begin
            seconds_d = seconds_q - 7'd1;
          end
          alarm_go = (seconds_q == 7'd0) || (seconds_q == 7'd1);
        end
      end
      clta_pkg::CMD_FLASH: begin
        if (tamper_q && (seconds_q == 7'd0)) begin
          led_d = !led_q;
        end
      end
      default: begin
      end
    endcase
  end

  // mode next state
  always_comb begin
    mode_d = mode_q;
    if (disarm_go) begin
      mode_d = clta_pkg::MODE_UNARMED;
    end else if (shake_go) begin
      mode_d = clta_pkg::MODE_PENDING;
    end else if (alarm_go) begin
      mode_d = clta_pkg::MODE_ALARMED;
    end else if (arm_go) begin
      mode_d = clta_pkg::MODE_ARMED;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= clta_pkg::MODE_UNARMED;
      lock_q    <= 1'b0;
      armed_q   <= 1'b0;
      tamper_q  <= 1'b0;
      led_q     <= 1'b0;
      cursor_q  <= '0;
      entries_q <= '{default: 4'd0};
      seconds_q <= 7'd0;
      last_q    <= 5'h1F;
    end else if (adv_o) begin
      mode_q    <= mode_d;
      lock_q    <= lock_d;
      armed_q   <= armed_d;
      tamper_q  <= tamper_d;
      led_q     <= led_d;
      cursor_q  <= cursor_d;
      entries_q <= entries_d;
      seconds_q <= seconds_d;
      last_q    <= last_d;
    end
  end

  // outputs
  assign out_valid_o     = out_valid_q;
  assign status_o.mode   = mode_q;
  assign status_o.lock   = lock_q;
  assign status_o.armed  = armed_q;
  assign status_o.tamper = tamper_q;
  assign status_o.led    = led_q;
  assign cursor_o        = cursor_q;
  assign entries_o       = entries_q;
  assign seconds_o       = seconds_q;

  `CLTA_ASSERT(a_armed_mode, clk_i, rst_ni, armed_q == (mode_q != clta_pkg::MODE_UNARMED), "armed flag disagrees with mode")
  `CLTA_ASSERT(a_tamper_mode, clk_i, rst_ni, tamper_q == ((mode_q == clta_pkg::MODE_PENDING) || (mode_q == clta_pkg::MODE_ALARMED)), "tamper flag disagrees with mode")
  `CLTA_ASSERT(a_cursor_range, clk_i, rst_ni, int'(cursor_q) < CODE_LEN, "cursor beyond code length")
  `CLTA_ASSERT_NEXT(a_hold_state, clk_i, rst_ni, !adv_o, $stable(mode_q) && $stable(seconds_q) && $stable(cursor_q), "state changed without a transfer")

endmodule

### tb/tb.sv
`timescale 1ns / 1ps

module tb;
  import clta_pkg::*;

  localparam int CODE_LEN = 4;
  localparam int CYCLE_LIMIT = 500000;
  localparam int NUM_PHASES = 6;
  localparam int ITEMS_PER_PHASE = 242;
  localparam int MAX_REPORTS = 10;
  localparam int POT_FULL = 4095;
  localparam int SECS_TOP = 120;
  localparam int SECS_DROP = 110;
  localparam logic [4:0] ALL_UP = 5'h1f;
  localparam logic [2:0] CMD_SPARE = 3'd7;
  localparam logic [2:0] REG_SPARE = REG_THRESHOLD + 3'd1;
  localparam logic [3:0] DIGIT_BAD = 4'd15;

  // One lock/alarm snapshot as reported after every event.
  typedef struct packed {
    logic [1:0] status;
    logic       lock;
    logic       armed;
    logic       tamper;
    logic [1:0] cur;
    logic [3:0] e0;
    logic [3:0] e1;
    logic [3:0] e2;
    logic [3:0] e3;
    logic [6:0] secs;
    logic       led;
  } alarm_view_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              cfg_we = 1'b0;
  logic [2:0]        cfg_index = '0;
  logic [9:0]        cfg_data = '0;
  logic              in_valid = 1'b0;
  logic              in_stall_o;
  logic [2:0]        command = '0;
  logic [4:0]        button_levels = ALL_UP;
  logic signed [9:0] accel_x = '0;
  logic signed [9:0] accel_y = '0;
  logic signed [9:0] accel_z = '0;
  logic [11:0]       pot_sample = '0;
  logic              out_valid_o;
  logic              out_stall = 1'b0;
  logic [1:0]        alarm_status_o;
  logic              lock_on_o;
  logic              armed_on_o;
  logic              tamper_seen_o;
  logic [1:0]        cursor_o;
  logic [3:0]        entry_0_o;
  logic [3:0]        entry_1_o;
  logic [3:0]        entry_2_o;
  logic [3:0]        entry_3_o;
  logic [6:0]        countdown_o;
  logic              led_lit_o;

  // Shadow of the lock: configuration and state after the last accepted event.
  logic [3:0]        secret_r [CODE_LEN] = '{4'd1, 4'd2, 4'd3, 4'd4};
  logic signed [9:0] thr_r = 10'sd50;
  logic              lock_r = 1'b0;
  logic              armed_r = 1'b0;
  logic              tamper_r = 1'b0;
  mode_e             mode_r = MODE_UNARMED;
  logic [1:0]        cur_r = '0;
  logic [3:0]        dig_r [CODE_LEN] = '{default: 4'd0};
  logic [6:0]        secs_r = '0;
  logic [4:0]        last_lv_r = ALL_UP;
  logic              led_r = 1'b0;

  item_t       evt_q [$];
  alarm_view_t want_q [$];
  item_t       cur_evt;
  int          push_cnt = 0;
  int          acc_cnt = 0;
  int          err_cnt = 0;
  int          cyc_cnt = 0;

  code_lock_tamper_alarm #(
    .CODE_LEN(CODE_LEN)
  ) uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall_o),
    .command_i      (command),
    .button_levels_i(button_levels),
    .accel_x_i      (accel_x),
    .accel_y_i      (accel_y),
    .accel_z_i      (accel_z),
    .pot_sample_i   (pot_sample),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall),
    .alarm_status_o (alarm_status_o),
    .lock_on_o      (lock_on_o),
    .armed_on_o     (armed_on_o),
    .tamper_seen_o  (tamper_seen_o),
    .cursor_o       (cursor_o),
    .entry_0_o      (entry_0_o),
    .entry_1_o      (entry_1_o),
    .entry_2_o      (entry_2_o),
    .entry_3_o      (entry_3_o),
    .countdown_o    (countdown_o),
    .led_lit_o      (led_lit_o)
  );

  always #6 clk_i = ~clk_i;

  // Abort a run that hangs.
  always @(posedge clk_i) begin
    cyc_cnt++;
    if (cyc_cnt >= CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Roughly one cycle in five idles, except in a quiet window of each period.
  function automatic bit idle_roll();
    if (cyc_cnt % 3000 >= 2300) return 1'b0;
    return $urandom_range(99) < 20;
  endfunction

  // Advance the shadow lock by one event and report the resulting snapshot.
  task automatic step_lock(input item_t it, output alarm_view_t v);
    logic [4:0] edges;
    logic [1:0] pos;
    logic       hit;
    int         drop;
    case (it.command)
      CMD_POLL: begin
        // release edge: was pressed (0), now released (1)
        edges = ~last_lv_r & it.button_levels;
        last_lv_r = it.button_levels;
        if (!armed_r) begin
          if (edges[BTN_UP]) begin
            lock_r = 1'b1;
          end else if (edges[BTN_DOWN]) begin
            lock_r = 1'b0;
          end else if (edges[BTN_LEFT] && lock_r) begin
            armed_r = 1'b1;
            mode_r = MODE_ARMED;
            // the arming poll uses up its left, up and down edges
            edges[BTN_LEFT] = 1'b0;
            edges[BTN_UP] = 1'b0;
            edges[BTN_DOWN] = 1'b0;
          end
        end
        if (armed_r) begin
          pos = cur_r;
          if (edges[BTN_RIGHT]) begin
            if (cur_r < CODE_LEN - 1) cur_r++;
          end else if (edges[BTN_LEFT]) begin
            if (cur_r > 0) cur_r--;
          end else if (edges[BTN_UP]) begin
            if (dig_r[pos] < DIGIT_MAX) dig_r[pos]++;
          end else if (edges[BTN_DOWN]) begin
            if (dig_r[pos] > 0) dig_r[pos]--;
          end else if (edges[BTN_CENTRE]) begin
            hit = 1'b1;
            for (int i = 0; i < CODE_LEN; i++) begin
              if (dig_r[i] != secret_r[i]) hit = 1'b0;
            end
            if (hit) begin
              armed_r = 1'b0;
              tamper_r = 1'b0;
              lock_r = 1'b0;
              mode_r = MODE_UNARMED;
            end
          end
        end
      end
      CMD_ACCEL: begin
        if (armed_r && ($signed(it.accel_x) > thr_r || $signed(it.accel_y) > thr_r ||
                        $signed(it.accel_z) > thr_r)) begin
          tamper_r = 1'b1;
          mode_r = MODE_PENDING;
        end
      end
      CMD_POT: begin
        if (!armed_r) begin
          // round the drop up: 120 - ceil(110 * pot / 4095)
          drop = (SECS_DROP * int'(it.pot_sample) + POT_FULL - 1) / POT_FULL;
          secs_r = 7'(SECS_TOP - drop);
        end
      end
      CMD_TICK: begin
        if (mode_r == MODE_PENDING && secs_r != 0) secs_r--;
        if (mode_r == MODE_PENDING && secs_r == 0) mode_r = MODE_ALARMED;
      end
      CMD_FLASH: begin
        if (tamper_r && secs_r == 0) led_r = ~led_r;
      end
      default: begin
      end
    endcase
    v.status = mode_r;
    v.lock = lock_r;
    v.armed = armed_r;
    v.tamper = tamper_r;
    v.cur = cur_r;
    v.e0 = dig_r[0];
    v.e1 = dig_r[1];
    v.e2 = dig_r[2];
    v.e3 = dig_r[3];
    v.secs = secs_r;
    v.led = led_r;
  endtask

  // Event driver: hold a stalled transfer, otherwise load the next event or idle.
  always @(posedge clk_i) begin : event_driver
    alarm_view_t want;
    if (!rst_ni) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall_o) begin
        step_lock(cur_evt, want);
        want_q.push_back(want);
        acc_cnt++;
      end
      if (!in_valid || !in_stall_o) begin
        if (evt_q.size() != 0 && !idle_roll()) begin
          cur_evt = evt_q.pop_front();
          in_valid <= 1'b1;
          command <= cur_evt.command;
          button_levels <= cur_evt.button_levels;
          accel_x <= cur_evt.accel_x;
          accel_y <= cur_evt.accel_y;
          accel_z <= cur_evt.accel_z;
          pot_sample <= cur_evt.pot_sample;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  task automatic check_field(input string what, input int unsigned want_v, got_v);
    if (want_v != got_v) begin
      err_cnt++;
      if (err_cnt <= MAX_REPORTS)
        $display("%0t: %s mismatch, expected %0d, got %0d", $realtime, what, want_v, got_v);
    end
  endtask

  // Result monitor: compare each transfer against the oldest expected snapshot.
  always @(posedge clk_i) begin : result_monitor
    alarm_view_t want;
    if (!rst_ni) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall) begin
        if (want_q.size() == 0) begin
          err_cnt++;
          if (err_cnt <= MAX_REPORTS)
            $display("%0t: result transfer with nothing expected", $realtime);
        end else begin
          want = want_q.pop_front();
          check_field("alarm_status", want.status, alarm_status_o);
          check_field("lock_on", want.lock, lock_on_o);
          check_field("armed_on", want.armed, armed_on_o);
          check_field("tamper_seen", want.tamper, tamper_seen_o);
          check_field("cursor", want.cur, cursor_o);
          check_field("entry_0", want.e0, entry_0_o);
          check_field("entry_1", want.e1, entry_1_o);
          check_field("entry_2", want.e2, entry_2_o);
          check_field("entry_3", want.e3, entry_3_o);
          check_field("countdown", want.secs, countdown_o);
          check_field("led_lit", want.led, led_lit_o);
        end
      end
      out_stall <= idle_roll();
    end
  end

  // ---------------------------------------------------------------- stimulus

  task automatic post(input item_t it);
    evt_q.push_back(it);
    push_cnt++;
  endtask

  task automatic post_fields(input logic [2:0] c, input logic [4:0] lv,
                             input int x, input int y, input int z, input int pot);
    item_t it;
    it.command = c;
    it.button_levels = lv;
    it.accel_x = 10'(x);
    it.accel_y = 10'(y);
    it.accel_z = 10'(z);
    it.pot_sample = 12'(pot);
    post(it);
  endtask

  // Random payload in every field, with the given command.
  function automatic item_t rnd_item(input logic [2:0] c);
    logic [63:0] r;
    item_t       it;
    r = {$urandom, $urandom};
    it = r[49:0];
    it.command = c;
    return it;
  endfunction

  task automatic poll(input logic [4:0] lv);
    item_t it;
    it = rnd_item(CMD_POLL);
    it.button_levels = lv;
    post(it);
  endtask

  // Press and release one button.
  task automatic press(input int btn);
    logic [4:0] lv;
    lv = ALL_UP;
    lv[btn] = 1'b0;
    poll(lv);
    poll(ALL_UP);
  endtask

  // Accel sample above the threshold on one axis (random at 511), or at/below it on all.
  task automatic shake(input bit hard);
    item_t it;
    int    lo;
    int    v;
    it = rnd_item(CMD_ACCEL);
    if (hard && thr_r != 10'sd511) begin
      lo = int'(thr_r) + 1;
      v = lo + int'($urandom_range(511 - lo));
      case ($urandom_range(2))
        0: it.accel_x = 10'(v);
        1: it.accel_y = 10'(v);
        default: it.accel_z = 10'(v);
      endcase
    end else if (!hard) begin
      it.accel_x = 10'(-512 + int'($urandom_range(int'(thr_r) + 512)));
      it.accel_y = 10'(-512 + int'($urandom_range(int'(thr_r) + 512)));
      it.accel_z = 10'(-512 + int'($urandom_range(int'(thr_r) + 512)));
    end
    post(it);
  endtask

  // Wait until every queued event has been transferred into the block.
  task automatic sync();
    while (acc_cnt != push_cnt) @(posedge clk_i);
  endtask

  // Walk the cursor and step digits toward the secret (or a random guess), then submit.
  task automatic enter_code(input bit good);
    logic [3:0] d [CODE_LEN];
    int         c;
    int         tgt;
    sync();
    poll(ALL_UP);
    sync();
    if (!armed_r) return;
    c = cur_r;
    d = dig_r;
    for (int p = 0; p < CODE_LEN; p++) begin
      tgt = good ? int'(secret_r[p]) : int'($urandom_range(DIGIT_MAX));
      if (tgt > DIGIT_MAX) tgt = DIGIT_MAX;
      while (c > p) begin
        press(BTN_LEFT);
        c--;
      end
      while (c < p) begin
        press(BTN_RIGHT);
        c++;
      end
      while (d[p] < tgt) begin
        press(BTN_UP);
        d[p]++;
      end
      while (d[p] > tgt) begin
        press(BTN_DOWN);
        d[p]--;
      end
    end
    press(BTN_CENTRE);
  endtask

  // One pass through the lock's life: set the countdown, lock, arm, fiddle,
  // shake, tick the countdown, flash, and try to disarm.
  task automatic session();
    item_t it;
    sync();
    if (!armed_r) begin
      it = rnd_item(CMD_POT);
      if ($urandom_range(99) < 80) it.pot_sample = 12'($urandom_range(4095, 3800));
      post(it);
      press(BTN_UP);
      if ($urandom_range(99) < 20) begin
        press(BTN_DOWN);
        press(BTN_UP);
      end
      if ($urandom_range(99) < 20) begin
        // arm and step right on the same release
        poll(ALL_UP & ~(5'b1 << BTN_LEFT) & ~(5'b1 << BTN_RIGHT));
        poll(ALL_UP);
      end else begin
        press(BTN_LEFT);
      end
    end
    repeat ($urandom_range(4)) press(int'($urandom_range(BTN_DOWN)));
    if ($urandom_range(99) < 30) shake(1'b0);
    shake(1'b1);
    repeat ($urandom_range(22, 6)) post(rnd_item($urandom_range(99) < 25 ? CMD_FLASH : CMD_TICK));
    repeat ($urandom_range(4)) post(rnd_item(CMD_FLASH));
    if ($urandom_range(99) < 30) begin
      shake(1'b1);
      post(rnd_item(CMD_TICK));
    end
    repeat ($urandom_range(6)) post(rnd_item(3'($urandom_range(7))));
    if ($urandom_range(99) < 25) enter_code(1'b0);
    if ($urandom_range(99) < 85) enter_code(1'b1);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [9:0] data);
    @(posedge clk_i);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    if (idx < CODE_LEN) secret_r[idx] = data[3:0];
    else if (idx == REG_THRESHOLD) thr_r = data;
  endtask

  // Secret digits carry random upper data bits, which the block must ignore.
  task automatic write_secret(input int i, input logic [3:0] dig);
    write_reg(REG_SECRET_0 + 3'(i), {6'($urandom), dig});
  endtask

  task automatic program_phase(input int p);
    int bad;
    bad = $urandom_range(CODE_LEN - 1);
    for (int i = 0; i < CODE_LEN; i++) begin
      case (p)
        2: write_secret(i, 4'd0);
        3: write_secret(i, DIGIT_MAX);
        4: write_secret(i, (i == bad) ? DIGIT_BAD : 4'($urandom_range(DIGIT_MAX)));
        default: write_secret(i, 4'($urandom_range(DIGIT_MAX)));
      endcase
    end
    case (p)
      1: write_reg(REG_THRESHOLD, 10'($urandom_range(200)));
      2: write_reg(REG_THRESHOLD, 10'h200);
      3: begin
        write_reg(REG_THRESHOLD, 10'h1ff);
        write_reg(REG_SPARE, 10'($urandom));
      end
      4: write_reg(REG_THRESHOLD, 10'(-100 + int'($urandom_range(400))));
      default: write_reg(REG_THRESHOLD, 10'($urandom));
    endcase
    @(posedge clk_i);
    cfg_we <= 1'b0;
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed opening with the reset code and threshold.
    post_fields(CMD_POT, 5'h00, -512, -512, -512, 0);
    post_fields(CMD_POT, ALL_UP, 511, 511, 511, POT_FULL);
    post_fields(CMD_SPARE, 5'h00, 511, -512, 511, POT_FULL);
    post_fields(CMD_POLL, 5'h00, 0, 0, 0, 0);         // all pressed: no edges
    post_fields(CMD_POLL, ALL_UP, 0, 0, 0, 0);        // all released: up wins, lock
    post_fields(CMD_ACCEL, ALL_UP, 511, 511, 511, 0); // unarmed: shaking ignored
    post_fields(CMD_POLL, 5'b11100, 0, 0, 0, 0);
    post_fields(CMD_POLL, ALL_UP, 0, 0, 0, 0);        // arm, right edge moves cursor
    post_fields(CMD_POT, ALL_UP, 0, 0, 0, 0);         // armed: pot ignored
    post_fields(CMD_ACCEL, ALL_UP, 50, -512, 50, 0);  // at threshold: no tamper
    post_fields(CMD_ACCEL, ALL_UP, -512, -512, 51, 0);
    post_fields(CMD_FLASH, ALL_UP, 0, 0, 0, 0);       // countdown running: no flash
    repeat (10) post_fields(CMD_TICK, ALL_UP, 0, 0, 0, 0);
    post_fields(CMD_FLASH, ALL_UP, 0, 0, 0, 0);
    post_fields(CMD_ACCEL, ALL_UP, 511, 0, 0, 0);     // shake again from alarmed
    post_fields(CMD_TICK, ALL_UP, 0, 0, 0, 0);

    for (int p = 0; p < NUM_PHASES; p++) begin
      if (p > 0) begin
        // drop to idle before touching the registers
        sync();
        while (want_q.size() != 0) @(posedge clk_i);
        program_phase(p);
      end
      while (push_cnt < 25 + (p + 1) * ITEMS_PER_PHASE) session();
    end

    sync();
    while (want_q.size() != 0) @(posedge clk_i);
    // hold on to catch any stray result transfer
    repeat (10) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
